@@ rtl/tile_frame_diff_refresh_core_assert.svh @@
// Assertion macros for the tile frame difference refresh core.
// Included by the top level; no other dependencies.
`ifndef TILE_FRAME_DIFF_REFRESH_CORE_ASSERT_SVH
`define TILE_FRAME_DIFF_REFRESH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define TFDR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising clock edge out of reset.
`define TFDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFDR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define TFDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/tfdr_pkg.sv @@
// Shared types and constants of the tile frame difference refresh core.
// Used by the controller, the datapath and the top level; no dependencies.
package tfdr_pkg;

  // Command codes carried on the input tuser field.
  typedef enum logic [2:0] {
    OP_BEGIN_FRAME = 3'd0,
    OP_PIXEL       = 3'd1,
    OP_SET_IND     = 3'd2,
    OP_REFRESH     = 3'd3,
    OP_TOUCH       = 3'd4
  } tfdr_op_e;

  // Result kinds carried on the output tuser field.
  typedef enum logic {
    KIND_ROW = 1'b0,
    KIND_IND = 1'b1
  } tfdr_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_IND
  } tfdr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // an input transaction completes this cycle
    logic scan_start;  // the accepted command is a refresh
    logic row_step;    // compare and copy the current grid row
    logic ind_emit;    // issue the indicator result and copy indicators
  } tfdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_refresh;  // the offered command is a refresh
    logic out_free;    // the output register can take a result this cycle
    logic row_last;    // the current scan row is the final grid row
  } tfdr_stat_t;

  localparam int unsigned TILE_PITCH = 29;
  localparam int unsigned CENTER_Y   = 120;
  localparam int unsigned COL_MAX    = 255;
  localparam int unsigned RESET_ROW_WIDTH = 8;

endpackage

@@ rtl/tfdr_ctrl.sv @@
// Refresh sequencer of the tile frame difference refresh core.
// Depends on tfdr_pkg for the state, command and status types.
module tfdr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  tfdr_pkg::tfdr_stat_t stat_i,
  output tfdr_pkg::tfdr_cmd_t  cmd_o
);

  tfdr_pkg::tfdr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfdr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a refresh walks the grid rows, then issues the indicators.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfdr_pkg::ST_IDLE: begin
        if (s_valid_i && stat_i.is_refresh) state_d = tfdr_pkg::ST_SCAN;
      end
      tfdr_pkg::ST_SCAN: begin
        if (stat_i.out_free && stat_i.row_last) state_d = tfdr_pkg::ST_IND;
      end
      tfdr_pkg::ST_IND: begin
        if (stat_i.out_free) state_d = tfdr_pkg::ST_IDLE;
      end
      default: state_d = tfdr_pkg::ST_IDLE;
    endcase
  end

  // Outputs: row steps and the indicator issue only advance when the output register has room.
  always_comb begin
    s_ready_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      tfdr_pkg::ST_IDLE: begin
        s_ready_o         = 1'b1;
        cmd_o.accept      = s_valid_i;
        cmd_o.scan_start  = s_valid_i && stat_i.is_refresh;
      end
      tfdr_pkg::ST_SCAN: begin
        cmd_o.row_step = stat_i.out_free;
      end
      tfdr_pkg::ST_IND: begin
        cmd_o.ind_emit = stat_i.out_free;
      end
      default: begin
        s_ready_o = 1'b0;
        cmd_o     = '0;
      end
    endcase
  end

endmodule

@@ rtl/tfdr_datapath.sv @@
// Buffers, write pointer, row compare and output register of the refresh core.
// Depends on tfdr_pkg; driven by commands from tfdr_ctrl.
module tfdr_datapath #(
  parameter int GRID_COLUMNS = 8,
  parameter int GRID_ROWS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tfdr_pkg::tfdr_cmd_t  cmd_i,
  output tfdr_pkg::tfdr_stat_t stat_o,
  input  logic [2:0]           opcode_i,
  input  logic [7:0]           row_width_i,
  input  logic [7:0]           pixel_value_i,
  input  logic                 menu_flag_i,
  input  logic                 ready_flag_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 kind_o,
  output logic [2:0]           row_o,
  output logic [7:0]           screen_y_o,
  output logic [7:0]           change_mask_o,
  output logic [15:0]          row_values_o,
  output logic                 background_redraw_o,
  output logic                 last_o
);

  localparam int RowBits   = 2 * GRID_COLUMNS;
  localparam int RowIdxW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int RowCntW   = $clog2(GRID_ROWS + 1);
  localparam int TopY      = tfdr_pkg::CENTER_Y - (GRID_ROWS / 2) * tfdr_pkg::TILE_PITCH;

  tfdr_pkg::tfdr_op_e op;

  // Back and front buffers, one grid row per entry.
  logic [RowBits-1:0] back_q  [GRID_ROWS];
  logic [RowBits-1:0] front_q [GRID_ROWS];
  logic [GRID_ROWS-1:0] front_vld_q;
  logic [1:0] back_ind_q;
  logic [1:0] front_ind_q;
  logic       front_ind_vld_q;
  logic       bg_dirty_q;
  logic       bg_pend_q;

  // Frame write pointer.
  logic [7:0]         wcol_q;
  logic [RowCntW-1:0] wrow_q;
  logic [7:0]         width_q;
  logic [7:0]         col_inc;
  logic               write_open;
  logic [RowIdxW-1:0] wrow_idx;

  // Scan position and compare results.
  logic [RowIdxW-1:0] scan_row_q;
  logic [RowBits-1:0] cur_back;
  logic [RowBits-1:0] cur_front;
  logic [7:0]         row_mask;
  logic [1:0]         ind_mask;
  logic               load_row;
  logic               load_any;

  // Output register.
  logic        out_valid_q;
  logic        kind_q;
  logic [2:0]  row_q;
  logic [7:0]  screen_y_q;
  logic [7:0]  mask_q;
  logic [15:0] values_q;
  logic        bg_q;
  logic        last_q;

  assign op = tfdr_pkg::tfdr_op_e'(opcode_i);

  // Pixel write pointer arithmetic; the column saturates at its maximum.
  assign write_open = wrow_q < RowCntW'(GRID_ROWS);
  assign col_inc    = (wcol_q != 8'(tfdr_pkg::COL_MAX)) ? wcol_q + 8'd1 : wcol_q;
  assign wrow_idx   = wrow_q[RowIdxW-1:0];

  // Compare of the current scan row; an invalid front row differs everywhere.
  assign cur_back  = back_q[scan_row_q];
  assign cur_front = front_q[scan_row_q];
  always_comb begin
    row_mask = '0;
    for (int c = 0; c < GRID_COLUMNS; c++) begin
      row_mask[c] = !front_vld_q[scan_row_q] ||
                    (cur_front[2*c +: 2] != cur_back[2*c +: 2]);
    end
  end
  assign ind_mask = front_ind_vld_q ? (front_ind_q ^ back_ind_q) : 2'b11;

  assign load_row = cmd_i.row_step && (row_mask != 8'd0);
  assign load_any = load_row || cmd_i.ind_emit;

  assign stat_o.is_refresh = (op == tfdr_pkg::OP_REFRESH);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.row_last   = (scan_row_q == RowIdxW'(GRID_ROWS - 1));

  // Control state, back buffer and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_ROWS; r++) back_q[r] <= '0;
      front_vld_q     <= '0;
      back_ind_q      <= '0;
      front_ind_vld_q <= 1'b0;
      bg_dirty_q      <= 1'b1;
      bg_pend_q       <= 1'b0;
      wcol_q          <= '0;
      wrow_q          <= RowCntW'(GRID_ROWS);
      width_q         <= 8'(tfdr_pkg::RESET_ROW_WIDTH);
      scan_row_q      <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      // Input commands.
      if (cmd_i.accept) begin
        case (op)
          tfdr_pkg::OP_BEGIN_FRAME: begin
            width_q <= row_width_i;
            wcol_q  <= '0;
            wrow_q  <= '0;
          end
          tfdr_pkg::OP_PIXEL: begin
            if (write_open) begin
              for (int c = 0; c < GRID_COLUMNS; c++) begin
                if (wcol_q == 8'(c)) back_q[wrow_idx][2*c +: 2] <= pixel_value_i[1:0];
              end
              if (col_inc == width_q) begin
                wcol_q <= '0;
                wrow_q <= wrow_q + RowCntW'(1);
              end else begin
                wcol_q <= col_inc;
              end
            end
          end
          tfdr_pkg::OP_SET_IND: begin
            back_ind_q <= {ready_flag_i, menu_flag_i};
          end
          tfdr_pkg::OP_TOUCH: begin
            bg_dirty_q <= 1'b1;
          end
          default: ;
        endcase
      end

      // Start of a refresh: a pending background redraw invalidates the front.
      if (cmd_i.scan_start) begin
        scan_row_q <= '0;
        bg_pend_q  <= bg_dirty_q;
        if (bg_dirty_q) begin
          front_vld_q     <= '0;
          front_ind_vld_q <= 1'b0;
          bg_dirty_q      <= 1'b0;
        end
      end

      // Row scan step: the row becomes valid in the front buffer.
      if (cmd_i.row_step) begin
        front_vld_q[scan_row_q] <= 1'b1;
        scan_row_q <= scan_row_q + RowIdxW'(1);
      end
      if (cmd_i.ind_emit) front_ind_vld_q <= 1'b1;

      // Only the first result of a refresh carries the background flag.
      if (load_any) bg_pend_q <= 1'b0;

      // Output register handshake.
      if (load_any) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Front buffer contents and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_step) front_q[scan_row_q] <= cur_back;
    if (cmd_i.ind_emit) front_ind_q <= back_ind_q;
    if (load_row) begin
      kind_q     <= tfdr_pkg::KIND_ROW;
      row_q      <= 3'(scan_row_q);
      screen_y_q <= 8'(TopY) + 8'(8'(tfdr_pkg::TILE_PITCH) * 8'(scan_row_q));
      mask_q     <= row_mask;
      values_q   <= 16'(cur_back);
      bg_q       <= bg_pend_q;
      last_q     <= 1'b0;
    end else if (cmd_i.ind_emit) begin
      kind_q     <= tfdr_pkg::KIND_IND;
      row_q      <= '0;
      screen_y_q <= '0;
      mask_q     <= 8'(ind_mask);
      values_q   <= 16'(back_ind_q);
      bg_q       <= bg_pend_q;
      last_q     <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign row_o               = row_q;
  assign screen_y_o          = screen_y_q;
  assign change_mask_o       = mask_q;
  assign row_values_o        = values_q;
  assign background_redraw_o = bg_q;
  assign last_o              = last_q;

endmodule

@@ rtl/tile_frame_diff_refresh_core.sv @@
// Top level of the tile frame difference refresh core.
// Depends on tfdr_pkg, tfdr_ctrl, tfdr_datapath and the assertion header.
//
// Channel   Dir  Contents
// s_axis    in   tuser: opcode; tdata: row_width, pixel_value, menu_flag, ready_flag
// m_axis    out  tuser: kind; tlast: last; tdata: row, screen_y, change_mask,
//                row_values, background_redraw
//
// Commands other than refresh are taken in the idle state. A refresh is
// accepted, then compares and copies each grid row in turn, then issues
// the indicator result; rows without changes give no result. The single
// output register sets the pace when the sink stalls; the scan waits for
// it. Reset clears the back buffer and valid bits at once; no clearing pass is needed.
`include "tile_frame_diff_refresh_core_assert.svh"

module tile_frame_diff_refresh_core #(
  parameter int GRID_COLUMNS = 8,
  parameter int GRID_ROWS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // row_width[7:0], pixel_value[15:8],
                                       // menu_flag[16], ready_flag[17], zeros
  input  logic [2:0]  s_axis_tuser_i,  // opcode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // row[2:0], screen_y[10:3],
                                       // change_mask[18:11], row_values[34:19],
                                       // background_redraw[35], zeros
  output logic        m_axis_tuser_o,  // kind[0]
  output logic        m_axis_tlast_o
);

  tfdr_pkg::tfdr_cmd_t  cmd;
  tfdr_pkg::tfdr_stat_t stat;

  logic [2:0]  out_row;
  logic [7:0]  out_screen_y;
  logic [7:0]  out_mask;
  logic [15:0] out_values;
  logic        out_bg;

  // Sequencer.
  tfdr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Buffers and compare datapath.
  tfdr_datapath #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .opcode_i            (s_axis_tuser_i),
    .row_width_i         (s_axis_tdata_i[7:0]),
    .pixel_value_i       (s_axis_tdata_i[15:8]),
    .menu_flag_i         (s_axis_tdata_i[16]),
    .ready_flag_i        (s_axis_tdata_i[17]),
    .out_ready_i         (m_axis_tready_i),
    .out_valid_o         (m_axis_tvalid_o),
    .kind_o              (m_axis_tuser_o),
    .row_o               (out_row),
    .screen_y_o          (out_screen_y),
    .change_mask_o       (out_mask),
    .row_values_o        (out_values),
    .background_redraw_o (out_bg),
    .last_o              (m_axis_tlast_o)
  );

  // Result packing, first field in the low bits.
  assign m_axis_tdata_o = {4'd0, out_bg, out_values, out_mask, out_screen_y, out_row};

  // No input is taken while a refresh scan or indicator issue is in progress.
  `TFDR_ASSERT_NOW(a_no_accept_in_scan, clk_i, rst_ni, s_axis_tready_o, !(cmd.row_step || cmd.ind_emit), "input accepted during a refresh")
  // The indicator issue always leaves the closing result in the output register.
  `TFDR_ASSERT_NEXT(a_ind_gives_last, clk_i, rst_ni, cmd.ind_emit, m_axis_tvalid_o && m_axis_tlast_o, "indicator result missing")
  // Only indicator results close a refresh.
  `TFDR_ASSERT_NOW(a_last_is_ind, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tlast_o == m_axis_tuser_o, "last flag and kind disagree")

endmodule
